// File: src/gss_token_header_checker_unit_macros.svh
// ----------------------------------------------------------------------------
// gss_token_header_checker_unit_macros.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef GSS_TOKEN_HEADER_CHECKER_UNIT_MACROS_SVH
`define GSS_TOKEN_HEADER_CHECKER_UNIT_MACROS_SVH

// condition holds at every edge out of reset
`define GTHC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// antecedent implies consequent in the same cycle
`define GTHC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the following cycle
`define GTHC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/gthc_pkg.sv
// ----------------------------------------------------------------------------
// gthc_pkg
// shared types and constants of the token header checker
// ----------------------------------------------------------------------------
package gthc_pkg;

  localparam int MAX_OID_BYTES = 16;

  localparam logic [7:0] TAG_SEQUENCE = 8'h60;
  localparam logic [7:0] TAG_OID      = 8'h06;

  localparam int MIN_HEADER_LENGTH = 4;
  localparam int MAX_HEADER_LENGTH = 24;

  localparam int ADDR_WIDTH = 5;
  localparam int DATA_WIDTH = 64;

  typedef enum logic [1:0] {
    ST_COMPLETE   = 2'd0,
    ST_DEFECTIVE  = 2'd1,
    ST_WRONG_MECH = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_MECH_OID_LENGTH = 2'd0,
    REG_MECH_OID_LOW    = 2'd1,
    REG_MECH_OID_HIGH   = 2'd2
  } reg_index_t;

endpackage

// File: src/gss_token_header_checker_unit.sv
// ----------------------------------------------------------------------------
// gss_token_header_checker_unit
// parses the initial context token header one byte per transaction and
// reports complete, defective or wrong mechanism once per token
// ----------------------------------------------------------------------------
// channel   direction  handshake                  payload
// token     in         token_valid / token_stall  token_start, token_size, byte_value
// result    out        result_valid / result_stall status, payload_size, header_length
// config    in         apb psel / penable / pready paddr, pwdata, prdata
//
// one byte per cycle while token_stall is low; the verdict on the byte that ends a token is registered
// the header state and the result register sit around one level of compare logic
// a skid register holds one result while result_stall is high; token_stall rises
// only when that skid register is full
// rst is synchronous and clears the parse state and both result stages
// ----------------------------------------------------------------------------
module gss_token_header_checker_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             token_valid,
  output logic                             token_stall,
  input  logic                             token_start,
  input  logic [31:0]                      token_size,
  input  logic [7:0]                       byte_value,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [1:0]                       status,
  output logic [30:0]                      payload_size,
  output logic [4:0]                       header_length,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gthc_pkg::ADDR_WIDTH-1:0]  paddr,
  input  logic [gthc_pkg::DATA_WIDTH-1:0]  pwdata,
  output logic [gthc_pkg::DATA_WIDTH-1:0]  prdata,
  output logic                             pready
);
  import gthc_pkg::*;

  typedef enum logic [5:0] {
    PH_IDLE      = 6'b000001,
    PH_LEN_FIRST = 6'b000010,
    PH_LEN_MORE  = 6'b000100,
    PH_OID_TAG   = 6'b001000,
    PH_OID_LEN   = 6'b010000,
    PH_OID_BYTES = 6'b100000
  } phase_t;

  typedef struct packed {
    status_t     status;
    logic [30:0] payload_size;
    logic [4:0]  header_length;
  } result_t;

  logic [4:0]   mech_oid_length;
  logic [63:0]  mech_oid_low;
  logic [63:0]  mech_oid_high;
  logic [127:0] mech_oid;
  reg_index_t   reg_index;
  logic         cfg_write;

  phase_t      phase, phase_next;
  logic [31:0] bytes_remaining, bytes_remaining_next;
  logic [2:0]  length_bytes_left, length_bytes_left_next;
  logic [31:0] length_accumulator, length_accumulator_next;
  logic [4:0]  oid_byte_count, oid_byte_count_next;
  logic [4:0]  oid_byte_index, oid_byte_index_next;
  logic [4:0]  header_count, header_count_next;

  logic        accept;
  logic        res_valid;
  status_t     res_status;
  result_t     res;
  logic        out_free;

  logic        out_valid;
  result_t     out_data;
  logic        skid_valid;
  result_t     skid_data;

  // configuration port
  assign pready    = 1'b1;
  assign reg_index = reg_index_t'(paddr[4:3]);
  assign cfg_write = psel && penable && pwrite && pready;
  assign mech_oid  = {mech_oid_high, mech_oid_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      mech_oid_length <= '0;
      mech_oid_low    <= '0;
      mech_oid_high   <= '0;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_MECH_OID_LENGTH: mech_oid_length <= pwdata[4:0];
        REG_MECH_OID_LOW:    mech_oid_low    <= pwdata;
        REG_MECH_OID_HIGH:   mech_oid_high   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_MECH_OID_LENGTH: prdata = {59'd0, mech_oid_length};
      REG_MECH_OID_LOW:    prdata = mech_oid_low;
      REG_MECH_OID_HIGH:   prdata = mech_oid_high;
      default:             prdata = '0;
    endcase
  end

  // header parse
  assign token_stall = skid_valid;
  assign accept      = token_valid && !token_stall;

  always_comb begin
    phase_next              = phase;
    bytes_remaining_next    = bytes_remaining;
    length_bytes_left_next  = length_bytes_left;
    length_accumulator_next = length_accumulator;
    oid_byte_count_next     = oid_byte_count;
    oid_byte_index_next     = oid_byte_index;
    header_count_next       = header_count;
    res_valid               = 1'b0;
    res_status              = ST_DEFECTIVE;

    if (accept) begin
      if (token_start) begin
        bytes_remaining_next    = token_size - 32'd1;
        header_count_next       = 5'd1;
        length_bytes_left_next  = '0;
        length_accumulator_next = '0;
        oid_byte_count_next     = '0;
        oid_byte_index_next     = '0;
        if (token_size == 32'd0) begin
          bytes_remaining_next = '0;
          header_count_next    = '0;
          res_valid            = 1'b1;
        end else if (byte_value != TAG_SEQUENCE || token_size == 32'd1) begin
          res_valid = 1'b1;
        end else begin
          phase_next = PH_LEN_FIRST;
        end
      end else begin
        unique case (phase)
          PH_LEN_FIRST: begin
            bytes_remaining_next = bytes_remaining - 32'd1;
            header_count_next    = header_count + 5'd1;
            if (byte_value[7]) begin
              if ({25'd0, byte_value[6:0]} >= bytes_remaining_next ||
                  byte_value[6:0] > 7'd4 || byte_value[6:0] == 7'd0) begin
                res_valid = 1'b1;
              end else begin
                length_bytes_left_next  = byte_value[2:0];
                length_accumulator_next = '0;
                phase_next              = PH_LEN_MORE;
              end
            end else if ({24'd0, byte_value} != bytes_remaining_next ||
                         bytes_remaining_next == 32'd0) begin
              res_valid = 1'b1;
            end else begin
              phase_next = PH_OID_TAG;
            end
          end
          PH_LEN_MORE: begin
            length_accumulator_next = {length_accumulator[23:0], byte_value};
            bytes_remaining_next    = bytes_remaining - 32'd1;
            header_count_next       = header_count + 5'd1;
            length_bytes_left_next  = length_bytes_left - 3'd1;
            if (length_bytes_left_next == 3'd0) begin
              if (length_accumulator_next[31] ||
                  length_accumulator_next != bytes_remaining_next ||
                  bytes_remaining_next == 32'd0) begin
                res_valid = 1'b1;
              end else begin
                phase_next = PH_OID_TAG;
              end
            end
          end
          PH_OID_TAG: begin
            bytes_remaining_next = bytes_remaining - 32'd1;
            header_count_next    = header_count + 5'd1;
            if (byte_value != TAG_OID || bytes_remaining_next == 32'd0) begin
              res_valid = 1'b1;
            end else begin
              phase_next = PH_OID_LEN;
            end
          end
          PH_OID_LEN: begin
            header_count_next = header_count + 5'd1;
            if ({24'd0, byte_value} >= bytes_remaining) begin
              bytes_remaining_next = bytes_remaining - 32'd1;
              res_valid            = 1'b1;
            end else begin
              bytes_remaining_next = bytes_remaining - {24'd0, byte_value} - 32'd1;
              oid_byte_count_next  = byte_value[4:0];
              oid_byte_index_next  = '0;
              if (byte_value != {3'd0, mech_oid_length} ||
                  {24'd0, byte_value} > MAX_OID_BYTES) begin
                res_valid  = 1'b1;
                res_status = ST_WRONG_MECH;
              end else if (byte_value == 8'd0) begin
                res_valid  = 1'b1;
                res_status = ST_COMPLETE;
              end else begin
                phase_next = PH_OID_BYTES;
              end
            end
          end
          PH_OID_BYTES: begin
            header_count_next   = header_count + 5'd1;
            oid_byte_index_next = oid_byte_index + 5'd1;
            if (byte_value != mech_oid[{oid_byte_index[3:0], 3'b000} +: 8]) begin
              res_valid  = 1'b1;
              res_status = ST_WRONG_MECH;
            end else if (oid_byte_index_next >= oid_byte_count) begin
              res_valid  = 1'b1;
              res_status = ST_COMPLETE;
            end
          end
          PH_IDLE: ;
          default: phase_next = PH_IDLE;
        endcase
      end
      if (res_valid) begin
        phase_next = PH_IDLE;
      end
    end
  end

  always_comb begin
    res.status = res_status;
    if (res_status == ST_COMPLETE) begin
      res.payload_size  = bytes_remaining_next[30:0];
      res.header_length = header_count_next;
    end else begin
      res.payload_size  = '0;
      res.header_length = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_IDLE;
      bytes_remaining    <= '0;
      length_bytes_left  <= '0;
      length_accumulator <= '0;
      oid_byte_count     <= '0;
      oid_byte_index     <= '0;
      header_count       <= '0;
    end else begin
      phase              <= phase_next;
      bytes_remaining    <= bytes_remaining_next;
      length_bytes_left  <= length_bytes_left_next;
      length_accumulator <= length_accumulator_next;
      oid_byte_count     <= oid_byte_count_next;
      oid_byte_index     <= oid_byte_index_next;
      header_count       <= header_count_next;
    end
  end

  // result register with skid stage
  assign out_free = !out_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : res;
    end
    if (!out_free && res_valid) begin
      skid_data <= res;
    end
  end

  assign result_valid  = out_valid;
  assign status        = out_data.status;
  assign payload_size  = out_data.payload_size;
  assign header_length = out_data.header_length;

endmodule

// File: src/gthc_checker.sv
// ----------------------------------------------------------------------------
// gthc_checker
// port level checks of the token header checker, bound to gss_token_header_checker_unit
// ----------------------------------------------------------------------------
`include "gss_token_header_checker_unit_macros.svh"

module gthc_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic [1:0]  status,
  input logic [30:0] payload_size,
  input logic [4:0]  header_length
);
  import gthc_pkg::*;

  `GTHC_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(status) && $stable(payload_size) && $stable(header_length), "stalled result changed")
  `GTHC_ASSERT_IMPLY(a_failure_zero, result_valid && status != ST_COMPLETE, payload_size == 31'd0 && header_length == 5'd0, "failed token reports sizes")
  `GTHC_ASSERT_IMPLY(a_header_range, result_valid && status == ST_COMPLETE, header_length >= 5'(MIN_HEADER_LENGTH) && header_length <= 5'(MAX_HEADER_LENGTH), "header length out of range")
  `GTHC_ASSERT_IMPLY(a_reset_empty, $past(rst), !result_valid, "result present after reset")

endmodule

bind gss_token_header_checker_unit gthc_checker u_gthc_checker (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .status        (status),
  .payload_size  (payload_size),
  .header_length (header_length)
);

// File: bench/gss_token_header_monitor.sv
// ----------------------------------------------------------------------------
// gss_token_header_monitor
// watches the token, result and apb channels of the header checker, predicts
// the verdict of every token from the accepted bytes and the mechanism
// registers, and compares each accepted result with the oldest prediction
// ----------------------------------------------------------------------------
module gss_token_header_monitor (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            token_valid,
  input  logic                            token_stall,
  input  logic                            token_start,
  input  logic [31:0]                     token_size,
  input  logic [7:0]                      byte_value,
  input  logic                            result_valid,
  input  logic                            result_stall,
  input  logic [1:0]                      status,
  input  logic [30:0]                     payload_size,
  input  logic [4:0]                      header_length,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [gthc_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [gthc_pkg::DATA_WIDTH-1:0] pwdata,
  output int                              fail_count,
  output int                              pending_results
);
  timeunit 1ns;
  timeprecision 1ps;
  import gthc_pkg::*;

  typedef enum logic [5:0] {
    PH_IDLE      = 6'b000001,
    PH_SEQ_LEN   = 6'b000010,
    PH_LEN_BYTES = 6'b000100,
    PH_OID_TAG   = 6'b001000,
    PH_OID_LEN   = 6'b010000,
    PH_OID_BYTES = 6'b100000
  } parse_phase_t;

  typedef struct packed {
    status_t     verdict;
    logic [30:0] body;
    logic [4:0]  hlen;
  } header_verdict_t;

  header_verdict_t expected_verdicts [$];

  logic [4:0]   cfg_oid_len;
  logic [63:0]  cfg_oid_lo;
  logic [63:0]  cfg_oid_hi;

  parse_phase_t phase;
  logic [31:0]  left;
  logic [2:0]   len_left;
  logic [31:0]  len_acc;
  logic [7:0]   oid_cnt;
  logic [4:0]   oid_idx;
  logic [4:0]   hdr_cnt;

  function automatic void conclude(input status_t st);
    header_verdict_t v;
    v.verdict = st;
    v.body    = (st == ST_COMPLETE) ? left[30:0] : '0;
    v.hlen    = (st == ST_COMPLETE) ? hdr_cnt : '0;
    expected_verdicts.push_back(v);
    phase = PH_IDLE;
  endfunction

  function automatic void predict_header_byte(input logic s, input logic [31:0] sz,
                                              input logic [7:0] b);
    logic [7:0] n;
    logic [7:0] want_b;
    if (s) begin
      left     = sz;
      hdr_cnt  = '0;
      len_left = '0;
      len_acc  = '0;
      oid_cnt  = '0;
      oid_idx  = '0;
      if (left == 0) begin
        conclude(ST_DEFECTIVE);
        return;
      end
      left--;
      hdr_cnt = 5'd1;
      if (b != TAG_SEQUENCE || left == 0) conclude(ST_DEFECTIVE);
      else phase = PH_SEQ_LEN;
      return;
    end
    case (phase)
      PH_SEQ_LEN: begin
        left--;
        hdr_cnt++;
        if (b[7]) begin
          n = {1'b0, b[6:0]};
          if (32'(n) + 32'd1 > left || n > 8'd4 || n == 8'd0) begin
            conclude(ST_DEFECTIVE);
          end else begin
            len_left = n[2:0];
            len_acc  = '0;
            phase    = PH_LEN_BYTES;
          end
        end else if (32'(b) != left) begin
          conclude(ST_DEFECTIVE);
        end else if (left == 0) begin
          conclude(ST_DEFECTIVE);
        end else begin
          phase = PH_OID_TAG;
        end
      end
      PH_LEN_BYTES: begin
        len_acc = {len_acc[23:0], b};
        left--;
        hdr_cnt++;
        len_left--;
        if (len_left == 0) begin
          if (len_acc[31] || len_acc != left || left == 0) conclude(ST_DEFECTIVE);
          else phase = PH_OID_TAG;
        end
      end
      PH_OID_TAG: begin
        left--;
        hdr_cnt++;
        if (b != TAG_OID || left == 0) conclude(ST_DEFECTIVE);
        else phase = PH_OID_LEN;
      end
      PH_OID_LEN: begin
        left--;
        hdr_cnt++;
        if (32'(b) > left) begin
          conclude(ST_DEFECTIVE);
        end else begin
          left    = left - 32'(b);
          oid_cnt = b;
          if (b != 8'(cfg_oid_len) || int'(b) > MAX_OID_BYTES) begin
            conclude(ST_WRONG_MECH);
          end else if (b == 0) begin
            conclude(ST_COMPLETE);
          end else begin
            oid_idx = '0;
            phase   = PH_OID_BYTES;
          end
        end
      end
      PH_OID_BYTES: begin
        hdr_cnt++;
        want_b = oid_idx[3] ? cfg_oid_hi[8*oid_idx[2:0] +: 8]
                            : cfg_oid_lo[8*oid_idx[2:0] +: 8];
        if (b != want_b) begin
          conclude(ST_WRONG_MECH);
        end else begin
          oid_idx++;
          if (8'(oid_idx) >= oid_cnt) conclude(ST_COMPLETE);
        end
      end
      default: phase = PH_IDLE;
    endcase
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t ns: header mismatch: %s", $time, msg);
  endfunction

  always @(posedge clk) begin : watch
    header_verdict_t want;
    if (rst) begin
      cfg_oid_len = '0;
      cfg_oid_lo  = '0;
      cfg_oid_hi  = '0;
      phase       = PH_IDLE;
      left        = '0;
      len_left    = '0;
      len_acc     = '0;
      oid_cnt     = '0;
      oid_idx     = '0;
      hdr_cnt     = '0;
      expected_verdicts.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_verdicts.size() == 0) begin
          note_failure($sformatf("unexpected result status %0d body %0d hlen %0d",
                                 status, payload_size, header_length));
        end else begin
          want = expected_verdicts.pop_front();
          if (status != want.verdict || payload_size != want.body ||
              header_length != want.hlen)
            note_failure($sformatf("expected %s body %0d hlen %0d, got status %0d body %0d hlen %0d",
                                   want.verdict.name(), want.body, want.hlen,
                                   status, payload_size, header_length));
        end
      end
      if (token_valid && !token_stall)
        predict_header_byte(token_start, token_size, byte_value);
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[4:3]))
          REG_MECH_OID_LENGTH: cfg_oid_len = pwdata[4:0];
          REG_MECH_OID_LOW:    cfg_oid_lo  = pwdata;
          REG_MECH_OID_HIGH:   cfg_oid_hi  = pwdata;
          default: ;
        endcase
      end
    end
    pending_results = expected_verdicts.size();
  end

endmodule

// File: bench/tb_gss_token_header_checker_unit.sv
// ----------------------------------------------------------------------------
// tb_gss_token_header_checker_unit
// drives token bytes and mechanism register writes into the header checker:
// directed corner tokens first, then phases of mostly well-formed tokens with
// random content, corruptions, restarts and noise under several mechanisms,
// with random idling on both channels and one long result back-pressure
// ----------------------------------------------------------------------------
module tb_gss_token_header_checker_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import gthc_pkg::*;

  typedef logic [7:0] byte_q_t [$];

  localparam int CYCLE_LIMIT     = 300000;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int PHASES          = 8;

  logic                  clk;
  logic                  rst;
  logic                  token_valid;
  logic                  token_stall;
  logic                  token_start;
  logic [31:0]           token_size;
  logic [7:0]            byte_value;
  logic                  result_valid;
  logic                  result_stall;
  logic [1:0]            status;
  logic [30:0]           payload_size;
  logic [4:0]            header_length;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_WIDTH-1:0] paddr;
  logic [DATA_WIDTH-1:0] pwdata;
  logic [DATA_WIDTH-1:0] prdata;
  logic                  pready;

  int      fail_count;
  int      pending_results;
  bit      idle_on;
  bit      hold_req;
  int      items_sent;
  logic [4:0]  mech_len;
  logic [7:0]  mech_bytes [16];
  byte_q_t     hdr_q;
  logic [31:0] hdr_size;

  gss_token_header_checker_unit uut (
    .clk           (clk),
    .rst           (rst),
    .token_valid   (token_valid),
    .token_stall   (token_stall),
    .token_start   (token_start),
    .token_size    (token_size),
    .byte_value    (byte_value),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .status        (status),
    .payload_size  (payload_size),
    .header_length (header_length),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  gss_token_header_monitor header_monitor (
    .clk             (clk),
    .rst             (rst),
    .token_valid     (token_valid),
    .token_stall     (token_stall),
    .token_start     (token_start),
    .token_size      (token_size),
    .byte_value      (byte_value),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .status          (status),
    .payload_size    (payload_size),
    .header_length   (header_length),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: random stall bursts, or one long hold on request
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_stall <= 1'b1;
        repeat (80) @(negedge clk);
        result_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_byte(input logic s, input logic [31:0] sz, input logic [7:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      token_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    token_valid <= 1'b1;
    token_start <= s;
    token_size  <= sz;
    byte_value  <= b;
    @(posedge clk);
    while (token_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_token(input logic [31:0] sz, input byte_q_t bytes_in);
    int i;
    for (i = 0; i < bytes_in.size(); i++) send_byte(i == 0, sz, bytes_in[i]);
    items_sent += bytes_in.size();
  endtask

  task automatic drain();
    token_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_write(input reg_index_t idx, input logic [63:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_config(input logic [4:0] len, input logic [63:0] lo,
                              input logic [63:0] hi);
    int i;
    apb_write(REG_MECH_OID_LENGTH, 64'(len));
    apb_write(REG_MECH_OID_LOW, lo);
    apb_write(REG_MECH_OID_HIGH, hi);
    mech_len = len;
    for (i = 0; i < 8; i++) begin
      mech_bytes[i]     = lo[8*i +: 8];
      mech_bytes[i + 8] = hi[8*i +: 8];
    end
  endtask

  // well-formed header for the current mechanism into hdr_q / hdr_size
  function automatic void build_token(input int oid_len, input logic [31:0] body,
                                      input int nlen);
    logic [31:0] inner;
    int n;
    int i;
    inner = 32'(oid_len) + 32'd2 + body;
    n = nlen;
    hdr_q = {};
    hdr_q.push_back(TAG_SEQUENCE);
    if (n == 0 && inner < 128) begin
      hdr_q.push_back(inner[7:0]);
    end else begin
      if (n == 0) n = 1;
      while (n < 4 && (inner >> (8 * n)) != 0) n++;
      hdr_q.push_back(8'h80 | 8'(n));
      for (i = n - 1; i >= 0; i--) hdr_q.push_back(inner[8*i +: 8]);
    end
    hdr_size = 32'(hdr_q.size()) + inner;
    hdr_q.push_back(TAG_OID);
    hdr_q.push_back(8'(oid_len));
    for (i = 0; i < oid_len; i++) hdr_q.push_back(mech_bytes[i % 16]);
  endfunction

  task automatic random_token();
    int pick;
    int idx;
    logic [31:0] body;
    logic [31:0] acc;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 3)) begin
        send_byte($urandom_range(0, 1), $urandom_range(0, 1) ? $urandom : $urandom_range(0, 8),
                  8'($urandom));
        items_sent++;
      end
      return;
    end
    if (pick < 13) begin
      send_byte(1'b1, '0, 8'($urandom));
      items_sent++;
      return;
    end
    if (pick < 18) begin
      acc = 32'h8000_0000 | $urandom_range(0, 32'h7fff_fff0);
      hdr_q = {TAG_SEQUENCE, 8'h84, acc[31:24], acc[23:16], acc[15:8], acc[7:0], TAG_OID,
               8'h00};
      send_token(acc + 32'd6, hdr_q);
      return;
    end
    case ($urandom_range(0, 9)) inside
      [0:5]:   body = $urandom_range(0, 40);
      [6:7]:   body = $urandom_range(100, 70000);
      default: body = $urandom & 32'h3fff_ffff;
    endcase
    build_token(mech_len, body, $urandom_range(0, 4));
    if (pick < 28) begin
      if ($urandom_range(0, 1)) begin
        hdr_q[1] = $urandom_range(0, 1) ? 8'h80 : 8'($urandom_range(8'h81, 8'hff));
      end else begin
        idx = $urandom_range(0, hdr_q.size() - 1);
        hdr_q[idx] = hdr_q[idx] ^ (8'h01 << $urandom_range(0, 7));
      end
    end else if (pick < 34) begin
      if ($urandom_range(0, 1)) hdr_size = hdr_size + $urandom_range(1, 3);
      else hdr_size = hdr_size - $urandom_range(1, 3);
    end else if (pick < 40) begin
      hdr_q[hdr_q.size() - 1 - mech_len] = 8'($urandom_range(0, 20));
    end else if (pick < 46) begin
      idx = $urandom_range(1, hdr_q.size() - 1);
      while (hdr_q.size() > idx) void'(hdr_q.pop_back());
      send_token(hdr_size, hdr_q);
      return;
    end
    send_token(hdr_size, hdr_q);
    repeat ($urandom_range(0, 2)) begin
      send_byte(1'b0, $urandom, 8'($urandom));
      items_sent++;
    end
  endtask

  initial begin
    int p;
    int target;
    rst         = 1'b1;
    token_valid = 1'b0;
    token_start = 1'b0;
    token_size  = '0;
    byte_value  = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    idle_on     = 1'b1;
    hold_req    = 1'b0;
    items_sent  = 0;
    mech_len    = '0;
    foreach (mech_bytes[i]) mech_bytes[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // mechanism registers still at reset: empty identifier
    send_byte(1'b1, '0, 8'hff);
    send_token(32'd4, '{8'h60, 8'h02, 8'h06, 8'h00});
    send_token(32'd4, '{8'h61, 8'h02, 8'h06, 8'h00});
    send_token(32'd1, '{8'h60});
    send_token(32'd2, '{8'h60, 8'h00});
    send_token(32'd5, '{8'h60, 8'h80, 8'h06, 8'h00});
    send_token(32'd9, '{8'h60, 8'h85, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h06, 8'h00});
    send_token(32'd3, '{8'h60, 8'h82, 8'h00});
    send_token(32'h8000_0006, '{8'h60, 8'h84, 8'h80, 8'h00, 8'h00, 8'h00, 8'h06, 8'h00});
    send_token(32'h8000_0005, '{8'h60, 8'h84, 8'h7f, 8'hff, 8'hff, 8'hff, 8'h06, 8'h00});
    send_token(32'd5, '{8'h60, 8'h81, 8'h02, 8'h06, 8'h00});
    send_token(32'd4, '{8'h60, 8'h02, 8'h07, 8'h00});
    send_token(32'd3, '{8'h60, 8'h01, 8'h06});
    send_token(32'd4, '{8'h60, 8'h02, 8'h06, 8'h05});
    send_token(32'd5, '{8'h60, 8'h03, 8'h06, 8'h01, 8'h2a});
    send_token(32'd10, '{8'h60, 8'h08, 8'h06});
    send_token(32'd14, '{8'h60, 8'h0c, 8'h06, 8'h00});
    repeat (3) send_byte(1'b0, $urandom, 8'h60);

    drain();
    write_config(5'd16, '1, 64'h0123_4567_89ab_cdef);
    build_token(16, 32'd5, 0);
    send_token(hdr_size, hdr_q);
    build_token(16, 32'd0, 2);
    hdr_q[hdr_q.size() - 1] = hdr_q[hdr_q.size() - 1] ^ 8'h80;
    send_token(hdr_size, hdr_q);
    build_token(16, 32'd1, 0);
    hdr_q[hdr_q.size() - 16] = hdr_q[hdr_q.size() - 16] ^ 8'h01;
    send_token(hdr_size, hdr_q);

    drain();
    write_config(5'd31, rand64(), rand64());
    build_token(16, 32'd0, 0);
    send_token(hdr_size, hdr_q);
    build_token(31, 32'd3, 0);
    send_token(hdr_size, hdr_q);

    for (p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0:       write_config(5'd16, rand64(), rand64());
        1:       write_config(5'd1, rand64(), rand64());
        2:       write_config(5'd0, '1, '1);
        3:       write_config(5'($urandom_range(0, 16)), rand64(), rand64());
        4:       write_config(5'd8, '1, '0);
        5:       write_config(5'($urandom_range(17, 31)), rand64(), rand64());
        6:       write_config(5'd16, '0, '0);
        default: write_config(5'($urandom_range(1, 16)), rand64(), rand64());
      endcase
      idle_on = (p < 6);
      if (p == 3) begin
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (24) begin
          send_byte(1'b1, '0, 8'($urandom));
          items_sent++;
        end
        idle_on = 1'b1;
      end
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) random_token();
    end

    drain();
    repeat (6) @(negedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
